// ----- src/prlt_pkg.sv -----
package prlt_pkg;

  localparam int unsigned PRLT_DEPTH = 64;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned RTT_W  = 32;
  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned REQ_W  = 2;

  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam int unsigned RATE_SHIFT = 15;

  typedef struct packed {
    logic [RTT_W-1:0]  rtt;
    logic [TIME_W-1:0] send_time;
  } tbl_entry_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } tbl_cmd_t;

endpackage

// ----- src/packet_rtt_loss_tracker.sv -----
// Ack: read the slot, then write back its RTT. Clear: reset all slots. Report: walk the DEPTH
// slots, then divide for average RTT and success rate. One word at a time; a report is bound
// by the slot walk (one read per cycle) and up to two passes of the shared radix-2 divider.
// Reset: asynchronous, active low; all slots read as unused, sequence number restarts at 0.
module packet_rtt_loss_tracker
  import prlt_pkg::*;
#(
  parameter int unsigned DEPTH = PRLT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // now_ms[47:0], ack_seq[55:48]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // seq_num[7:0], avg_rtt_ms[39:8], success_rate[55:40]
);

  localparam int unsigned AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ACK     = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_AVG_GO  = 3'd3;
  localparam logic [2:0] ST_AVG_W   = 3'd4;
  localparam logic [2:0] ST_RATE_GO = 3'd5;
  localparam logic [2:0] ST_RATE_W  = 3'd6;
  localparam logic [2:0] ST_FIN     = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     seq_q, seq_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     sent_q, sent_d;
  logic [CW-1:0]     succ_q, succ_d;
  logic [RTT_W-1:0]  sum_q, sum_d;
  logic [RTT_W-1:0]  avg_q, avg_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic              mvld_q, mvld_d;
  logic [55:0]       mdat_q, mdat_d;

  tbl_cmd_t          tcmd;
  logic [AW-1:0]     rd_addr, wr_addr;
  tbl_entry_t        wr_data, rd_data;

  logic              div_start, div_done;
  logic [RTT_W-1:0]  div_dividend, div_quo;
  logic [CW-1:0]     div_divisor;

  logic [REQ_W-1:0]  in_req;
  logic [TIME_W-1:0] in_now;
  logic [SEQ_W-1:0]  in_ack;
  logic              in_acc;

  assign in_req = s_axis_tuser;
  assign in_now = s_axis_tdata[47:0];
  assign in_ack = s_axis_tdata[55:48];
  assign s_axis_tready = state_q == ST_IDLE;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    idx_d        = idx_q;
    seq_d        = seq_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    sent_d       = sent_q;
    succ_d       = succ_q;
    sum_d        = sum_q;
    avg_d        = avg_q;
    rate_d       = rate_q;
    mvld_d       = mvld_q;
    mdat_d       = mdat_q;
    tcmd         = '0;
    rd_addr      = idx_q;
    wr_addr      = idx_q;
    wr_data      = '0;
    div_start    = 1'b0;
    div_dividend = sum_q;
    div_divisor  = succ_q;

    if (mvld_q && m_axis_tready) begin
      mvld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d = in_now;
          priority if (in_req == REQ_REPORT) begin
            cnt_d   = '0;
            sent_d  = '0;
            succ_d  = '0;
            sum_d   = '0;
            state_d = ST_SCAN;
          end else if (in_req == REQ_ACK) begin
            if ({1'b0, in_ack} < 9'(DEPTH)) begin
              idx_d   = in_ack[AW-1:0];
              rd_addr = in_ack[AW-1:0];
              tcmd.rd = 1'b1;
              state_d = ST_ACK;
            end
          end else if (in_req == REQ_CLEAR) begin
            tcmd.clr = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ACK: begin
        wr_data.send_time = rd_data.send_time;
        wr_data.rtt       = now_q[RTT_W-1:0] - rd_data.send_time[RTT_W-1:0];
        tcmd.wr           = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_SCAN: begin
        if (cnt_q < CW'(DEPTH)) begin
          tcmd.rd = 1'b1;
          rd_addr = cnt_q[AW-1:0];
          cnt_d   = cnt_q + CW'(1);
          pend_d  = 1'b1;
        end
        if (pend_q && rd_data.send_time != '0) begin
          sent_d = sent_q + CW'(1);
          if (rd_data.rtt != '0) begin
            succ_d = succ_q + CW'(1);
            sum_d  = sum_q + rd_data.rtt;
          end
        end
        if (!pend_q && cnt_q == CW'(DEPTH)) begin
          state_d = ST_AVG_GO;
        end
      end
      ST_AVG_GO: begin
        if (succ_q == '0) begin
          avg_d   = '0;
          state_d = ST_RATE_GO;
        end else begin
          div_start = 1'b1;
          state_d   = ST_AVG_W;
        end
      end
      ST_AVG_W: begin
        if (div_done) begin
          avg_d   = div_quo;
          state_d = ST_RATE_GO;
        end
      end
      ST_RATE_GO: begin
        div_dividend = RTT_W'(succ_q) << RATE_SHIFT;
        div_divisor  = sent_q;
        if (sent_q == '0) begin
          rate_d  = '0;
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_RATE_W;
        end
      end
      ST_RATE_W: begin
        if (div_done) begin
          rate_d  = div_quo[RATE_W-1:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!mvld_q || m_axis_tready) begin
          wr_addr           = seq_q;
          wr_data.send_time = now_q;
          wr_data.rtt       = '0;
          tcmd.wr           = 1'b1;
          mvld_d            = 1'b1;
          mdat_d            = {rate_q, avg_q, SEQ_W'(seq_q)};
          seq_d             = (seq_q == AW'(DEPTH - 1)) ? '0 : seq_q + AW'(1);
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seq_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      mvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      mvld_q  <= mvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    idx_q  <= idx_d;
    sent_q <= sent_d;
    succ_q <= succ_d;
    sum_q  <= sum_d;
    avg_q  <= avg_d;
    rate_q <= rate_d;
    mdat_q <= mdat_d;
  end

  assign m_axis_tvalid = mvld_q;
  assign m_axis_tdata  = mdat_q;

  prlt_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tcmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  prlt_div #(
    .DW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule

// ----- src/prlt_table.sv -----
module prlt_table
  import prlt_pkg::*;
#(
  parameter int unsigned DEPTH = PRLT_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tbl_cmd_t                            cmd_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  tbl_entry_t                          wr_data_i,
  output tbl_entry_t                          rd_data_o
);

  tbl_entry_t             mem [DEPTH];
  logic       [DEPTH-1:0] valid_q;
  tbl_entry_t             rd_data_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.rd) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
      if (cmd_i.clr) begin
        valid_q <= '0;
      end else if (cmd_i.wr) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- src/prlt_div.sv -----
module prlt_div
  import prlt_pkg::*;
#(
  parameter int unsigned DW = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RTT_W-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic             done_o,
  output logic [RTT_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(RTT_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [RTT_W-1:0] quo_q, quo_d;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem_q, quo_q[RTT_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
      quo_d = {quo_q[RTT_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(RTT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
